### hw/rtl/three_level_feedback_queue_core_defines.svh
// Assertion macros shared by the checker files of the feedback queue core.
// Each macro expects clk and rst_n in scope.
`ifndef THREE_LEVEL_FEEDBACK_QUEUE_CORE_DEFINES_SVH
`define THREE_LEVEL_FEEDBACK_QUEUE_CORE_DEFINES_SVH

// Check cons in the same cycle as ante.
`define TLFQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons starting in the cycle after ante; cons may carry its own delay.
`define TLFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);

`endif

### hw/rtl/tlfq_pkg.sv
// Types and constants for the three-level feedback queue core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tlfq_pkg;

    localparam int IDX_W  = 6;
    localparam int LVL_W  = 2;
    localparam int LEVELS = 3;

    typedef enum logic [1:0] {
        KIND_ENQ  = 2'd0,
        KIND_DEQ  = 2'd1,
        KIND_PICK = 2'd2,
        KIND_NONE = 2'd3
    } tlfq_kind_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_DUP   = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } tlfq_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_RED,
        S_EXEC
    } tlfq_state_t;

    // Command from the sequencer to one level's row of cells.
    typedef struct packed {
        logic push;
        logic pop;
    } tlfq_row_cmd_t;

    // Status from one row back to the sequencer.
    typedef struct packed {
        logic empty;
        logic full;
        logic dup;
    } tlfq_row_stat_t;

endpackage

`default_nettype wire

### hw/rtl/tlfq_cell.sv
// One queue cell: holds a single process index, shifts toward the head on a pop,
// loads on a push at its own position, and flags a match with the search key.
// Depends on tlfq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlfq_cell
    import tlfq_pkg::*;
#(
    parameter int CELL_ID = 0,
    parameter int CNT_W   = 6
) (
    input  wire logic             clk,
    input  wire logic [CNT_W-1:0] count,
    input  wire logic             push,
    input  wire logic             pop,
    input  wire logic [IDX_W-1:0] key,
    input  wire logic [IDX_W-1:0] shift_in,
    output logic      [IDX_W-1:0] data,
    output logic                  hit
);

    logic [IDX_W-1:0] data_reg;
    logic [IDX_W-1:0] data_next;
    logic             hit_reg;
    logic             occupied;
    logic             at_tail;

    assign occupied = CNT_W'(CELL_ID) < count;
    assign at_tail  = CNT_W'(CELL_ID) == count;

    always_comb
    begin
        data_next = data_reg;
        if (push && at_tail)
        begin
            data_next = key;
        end
        else if (pop)
        begin
            data_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        hit_reg  <= occupied && (data_reg == key);
    end

    assign data = data_reg;
    assign hit  = hit_reg;

endmodule

`default_nettype wire

### hw/rtl/tlfq_row.sv
// One priority level: a row of tlfq_cell with the head at cell 0 and a fill count.
// Depends on tlfq_pkg and tlfq_cell.
`timescale 1ns / 1ps
`default_nettype none

module tlfq_row
    import tlfq_pkg::*;
#(
    parameter int QUEUE_SLOTS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire tlfq_row_cmd_t    cmd,
    input  wire logic [IDX_W-1:0] key,
    output logic      [IDX_W-1:0] head,
    output tlfq_row_stat_t        stat
);

    localparam int CELLS = QUEUE_SLOTS - 1;
    localparam int CNT_W = $clog2(QUEUE_SLOTS);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             dup_reg;
    logic [IDX_W-1:0] cell_data [CELLS];
    logic [CELLS-1:0] cell_hit;

    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        logic [IDX_W-1:0] shift_in;

        if (g == CELLS - 1)
        begin : g_last
            assign shift_in = cell_data[g];
        end
        else
        begin : g_mid
            assign shift_in = cell_data[g + 1];
        end

        tlfq_cell #(
            .CELL_ID (g),
            .CNT_W   (CNT_W)
        ) u_cell (
            .clk      (clk),
            .count    (count_reg),
            .push     (cmd.push),
            .pop      (cmd.pop),
            .key      (key),
            .shift_in (shift_in),
            .data     (cell_data[g]),
            .hit      (cell_hit[g])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Fold the per-cell match flags in the cycle after the cells register them.
    always_ff @(posedge clk)
    begin
        dup_reg <= |cell_hit;
    end

    assign head       = cell_data[0];
    assign stat.empty = count_reg == '0;
    assign stat.full  = count_reg == CNT_W'(CELLS);
    assign stat.dup   = dup_reg;

endmodule

`default_nettype wire

### hw/rtl/three_level_feedback_queue_core.sv
// Top level of the three-level feedback queue: command sequencer over three rows of cells.
// Depends on tlfq_pkg, tlfq_row and tlfq_cell.
//
//   channel   handshake              ports
//   -------   --------------------   ---------------------------------
//   request   start high, busy low   kind, level, proc_index
//   result    done high, one cycle   status, out_index, served_level
//
// A request runs through these steps in order before another is taken:
// the cells compare against the key, the row match flags are folded into
// one register, then the sequencer pushes or pops. The result shows with done
// in the cycle after, which is also the first cycle a new request is taken.
// Reset clears the fill counts, so every level starts empty. The receiver
// cannot stall; done lasts exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module three_level_feedback_queue_core
    import tlfq_pkg::*;
#(
    parameter int QUEUE_SLOTS = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       kind,
    input  wire logic [LVL_W-1:0] level,
    input  wire logic [IDX_W-1:0] proc_index,
    output logic                  busy,
    output logic                  done,
    output logic      [1:0]       status,
    output logic      [IDX_W-1:0] out_index,
    output logic      [LVL_W-1:0] served_level
);

    tlfq_state_t      state_reg;
    tlfq_state_t      state_next;
    logic [1:0]       kind_reg;
    logic [LVL_W-1:0] level_reg;
    logic [IDX_W-1:0] key_reg;
    logic             done_reg;
    logic             done_next;
    tlfq_status_t     status_reg;
    tlfq_status_t     status_next;
    logic [IDX_W-1:0] index_reg;
    logic [IDX_W-1:0] index_next;
    logic [LVL_W-1:0] served_reg;
    logic [LVL_W-1:0] served_next;
    logic             accept;

    tlfq_row_cmd_t    row_cmd  [LEVELS];
    tlfq_row_stat_t   row_stat [LEVELS];
    logic [IDX_W-1:0] row_head [LEVELS];

    for (genvar g = 0; g < LEVELS; g++)
    begin : g_row
        tlfq_row #(
            .QUEUE_SLOTS (QUEUE_SLOTS)
        ) u_row (
            .clk   (clk),
            .rst_n (rst_n),
            .cmd   (row_cmd[g]),
            .key   (key_reg),
            .head  (row_head[g]),
            .stat  (row_stat[g])
        );
    end

    assign accept = start && (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg  <= kind;
            level_reg <= level;
            key_reg   <= proc_index;
        end
        if (state_reg == S_EXEC)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            served_reg <= served_next;
        end
    end

    always_comb
    begin
        logic found;

        found       = 1'b0;
        state_next  = state_reg;
        done_next   = 1'b0;
        status_next = STAT_OK;
        index_next  = '0;
        served_next = '0;
        for (int l = 0; l < LEVELS; l++)
        begin
            row_cmd[l] = '0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                state_next = S_RED;
            end
            S_RED:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (kind_reg)
                    KIND_ENQ:
                    begin
                        index_next  = key_reg;
                        served_next = level_reg;
                        if (level_reg >= LVL_W'(LEVELS))
                        begin
                            status_next = STAT_FULL;
                        end
                        else if (row_stat[level_reg].dup)
                        begin
                            status_next = STAT_DUP;
                        end
                        else if (row_stat[level_reg].full)
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            row_cmd[level_reg].push = 1'b1;
                        end
                    end
                    KIND_DEQ:
                    begin
                        served_next = level_reg;
                        if (level_reg >= LVL_W'(LEVELS))
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else if (row_stat[level_reg].empty)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            index_next             = row_head[level_reg];
                            row_cmd[level_reg].pop = 1'b1;
                        end
                    end
                    KIND_PICK:
                    begin
                        // Serve the highest level that holds anything.
                        status_next = STAT_EMPTY;
                        for (int l = 0; l < LEVELS; l++)
                        begin
                            if (!found && !row_stat[l].empty)
                            begin
                                found          = 1'b1;
                                status_next    = STAT_OK;
                                index_next     = row_head[l];
                                served_next    = LVL_W'(l);
                                row_cmd[l].pop = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = STAT_OK;
                    end
                endcase
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy         = state_reg != S_IDLE;
    assign done         = done_reg;
    assign status       = status_reg;
    assign out_index    = index_reg;
    assign served_level = served_reg;

endmodule

`default_nettype wire

### hw/rtl/tlfq_checker.sv
// Port-level checks for three_level_feedback_queue_core, attached by bind.
// Depends on tlfq_pkg and three_level_feedback_queue_core_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "three_level_feedback_queue_core_defines.svh"

module tlfq_checker
    import tlfq_pkg::*;
(
    input wire logic             clk,
    input wire logic             rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire logic             done,
    input wire logic [1:0]       status,
    input wire logic [IDX_W-1:0] out_index
);

    `TLFQ_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `TLFQ_ASSERT_NEXT(a_accept_done, start && !busy, ##3 done, "no result 4 cycles after accept")
    `TLFQ_ASSERT_NOW(a_done_idle, done, !busy, "result word while still busy")
    `TLFQ_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `TLFQ_ASSERT_NOW(a_empty_zero, done && status == STAT_EMPTY, out_index == '0, "index not zero")

endmodule

bind three_level_feedback_queue_core tlfq_checker u_tlfq_checker (.*);

`default_nettype wire
